FILE: hdl/msa_pkg.sv
// Shared types and constants for the multidimensional array store.
// No dependencies; every other file imports this package.
package msa_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int MEM_DEPTH  = 4096;
  localparam int ELEM_WIDTH = 32;

  localparam int DATA_W   = 32;                            // port width of element values
  localparam int IDX_W    = 12;                            // index field width
  localparam int BOUND_W  = 13;                            // bound register width
  localparam int DIMS_W   = 3;                             // dims_in_use register width
  localparam int CFG_W    = BOUND_W;                       // widest register
  localparam int CFG_IDX_W = $clog2(MAX_DIMS + 1);
  localparam int NDIM_W   = $clog2(MAX_DIMS + 1);
  localparam int DIX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int OFF_W    = $clog2(MEM_DEPTH);
  localparam int TOT_W    = $clog2(MEM_DEPTH + 2);         // holds the saturated total
  localparam int PROD_W   = TOT_W + BOUND_W;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_DIMS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BOUND0 = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SHAPE = 2'd2
  } status_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SH_START,
    SH_RUN,
    SH_IDLE
  } shape_state_t;

  typedef struct packed {
    logic [NDIM_W-1:0]                n;
    logic [MAX_DIMS-1:0][BOUND_W-1:0] bound;
    logic [MAX_DIMS-1:0][TOT_W-1:0]   stride;
    logic                             bad;
    logic                             busy;
  } shape_t;

  typedef struct packed {
    op_t                op;
    logic [DATA_W-1:0]  value;
    logic [OFF_W-1:0]   offset;
    status_t            status;
  } acc_t;

endpackage

FILE: hdl/msa_shape.sv
// Shape registers and the row-major stride sequencer, one multiply per cycle.
// Depends on msa_pkg.
module msa_shape import msa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output shape_t               shape
);

  shape_state_t                     state, state_next;
  logic [DIMS_W-1:0]                dims;
  logic [MAX_DIMS-1:0][BOUND_W-1:0] bound;
  logic [MAX_DIMS-1:0][TOT_W-1:0]   stride;
  logic [NDIM_W-1:0]                n;
  logic [NDIM_W-1:0]                cnt;
  logic [TOT_W-1:0]                 total;
  logic                             bad;
  logic                             busy;
  logic [NDIM_W-1:0]                n_clamp;
  logic [NDIM_W-1:0]                cnt_m1;
  logic [DIX_W-1:0]                 dix;
  logic [PROD_W-1:0]                prod;
  logic                             cfg_hit;
  logic [CFG_IDX_W-1:0]             bsel_full;
  logic [DIX_W-1:0]                 bsel;

  always_comb begin
    priority if (dims == '0) begin
      n_clamp = NDIM_W'(1);
    end else if (int'(dims) > MAX_DIMS) begin
      n_clamp = NDIM_W'(MAX_DIMS);
    end else begin
      n_clamp = NDIM_W'(dims);
    end
  end

  assign cnt_m1    = cnt - NDIM_W'(1);
  assign dix       = cnt_m1[DIX_W-1:0];
  assign prod      = PROD_W'(total) * PROD_W'(bound[dix]);
  assign bsel_full = cfg_index - REG_BOUND0;
  assign bsel      = bsel_full[DIX_W-1:0];
  assign cfg_hit   = cfg_we && (int'(cfg_index) <= MAX_DIMS);

  always_comb begin
    state_next = state;
    priority if (cfg_hit) begin
      state_next = SH_START;
    end else begin
      unique case (state)
        SH_START: state_next = SH_RUN;
        SH_RUN:   state_next = (cnt == NDIM_W'(1)) ? SH_IDLE : SH_RUN;
        SH_IDLE:  state_next = SH_IDLE;
        default:  state_next = SH_START;
      endcase
    end
  end

  always_comb begin
    busy = (state != SH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SH_START;
      dims  <= DIMS_W'(1);
      for (int d = 0; d < MAX_DIMS; d++) begin
        bound[d] <= BOUND_W'(1);
      end
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        if (cfg_index == REG_DIMS) begin
          dims <= cfg_data[DIMS_W-1:0];
        end else begin
          bound[bsel] <= cfg_data[BOUND_W-1:0];
        end
      end
    end
  end

  // walk from the innermost used dimension outward, saturating past the memory size
  always_ff @(posedge clk) begin
    if (state == SH_START) begin
      n     <= n_clamp;
      cnt   <= n_clamp;
      total <= TOT_W'(1);
      bad   <= 1'b0;
    end else if (state == SH_RUN) begin
      stride[dix] <= total;
      cnt         <= cnt_m1;
      if (prod > PROD_W'(MEM_DEPTH)) begin
        bad   <= 1'b1;
        total <= TOT_W'(MEM_DEPTH + 1);
      end else begin
        total <= prod[TOT_W-1:0];
      end
    end
  end

  assign shape.n      = n;
  assign shape.bound  = bound;
  assign shape.stride = stride;
  assign shape.bad    = bad;
  assign shape.busy   = busy;

endmodule

FILE: hdl/msa_front.sv
// Front end: takes access beats, checks indexes, forms per-dimension products
// and the offset, and pushes classified accesses to the queue. Depends on msa_pkg.
module msa_front import msa_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  shape_t                         shape,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  op_t                            op,
  input  logic [DATA_W-1:0]              write_value,
  input  logic [MAX_DIMS-1:0][IDX_W-1:0] index,
  input  logic                           q_full,
  output logic                           q_push,
  output acc_t                           q_data
);

  logic                           a_valid;
  op_t                            a_op;
  logic [DATA_W-1:0]              a_value;
  status_t                        a_status;
  logic [MAX_DIMS-1:0][OFF_W-1:0] a_prod;

  logic                           a_take;
  logic                           range_bad;
  status_t                        status_c;
  logic [MAX_DIMS-1:0][OFF_W-1:0] prod_c;
  logic [IDX_W+OFF_W-1:0]         full_prod;
  logic [OFF_W-1:0]               sum;

  assign q_push   = a_valid && !q_full;
  assign in_stall = shape.busy || (a_valid && q_full);
  assign a_take   = in_valid && !in_stall;

  // products stay below the memory depth whenever every index is in range,
  // so only the low offset bits are kept
  always_comb begin
    range_bad = 1'b0;
    full_prod = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      prod_c[d] = '0;
      if (NDIM_W'(d) < shape.n) begin
        if ({1'b0, index[d]} >= shape.bound[d]) begin
          range_bad = 1'b1;
        end
        full_prod = (IDX_W+OFF_W)'(index[d]) * (IDX_W+OFF_W)'(shape.stride[d][OFF_W-1:0]);
        prod_c[d] = full_prod[OFF_W-1:0];
      end
    end
    priority if (shape.bad) begin
      status_c = ST_SHAPE;
    end else if (range_bad) begin
      status_c = ST_RANGE;
    end else begin
      status_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_take) begin
      a_valid <= 1'b1;
    end else if (q_push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_op     <= op;
      a_value  <= write_value;
      a_status <= status_c;
      a_prod   <= prod_c;
    end
  end

  always_comb begin
    sum = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      sum = sum + a_prod[d];
    end
    q_data.op     = a_op;
    q_data.value  = a_value;
    q_data.status = a_status;
    q_data.offset = (a_status == ST_OK) ? sum : '0;
  end

endmodule

FILE: hdl/msa_queue.sv
// Short FIFO of classified accesses between front and back end.
// Depends on msa_pkg.
module msa_queue import msa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  acc_t push_data,
  output logic full,
  output logic valid,
  output acc_t head,
  input  logic pop
);

  acc_t              entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign valid = (count != '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hdl/msa_back.sv
// Back end: element memory access and the output register.
// Depends on msa_pkg.
module msa_back import msa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  acc_t                     q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] read_data,
  output logic [OFF_W-1:0]         element_offset,
  output status_t                  status
);

  logic signed [ELEM_WIDTH-1:0] mem [MEM_DEPTH];
  logic signed [ELEM_WIDTH-1:0] mem_q;
  logic                         show_data;
  logic                         do_write;

  assign q_pop    = q_valid && (!out_valid || !out_stall);
  assign do_write = (q_head.status == ST_OK) && (q_head.op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (do_write) begin
        mem[q_head.offset] <= ELEM_WIDTH'($signed(q_head.value));
      end else begin
        mem_q <= mem[q_head.offset];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      show_data      <= (q_head.status == ST_OK) && (q_head.op == OP_READ);
      element_offset <= q_head.offset;
      status         <= q_head.status;
    end
  end

  // mem_q holds still while the beat is stalled, since nothing pops then
  assign read_data = show_data ? DATA_W'(mem_q) : '0;

endmodule

FILE: hdl/multidim_array_store.sv
// Top level of the row-major multidimensional array store.
// Depends on msa_pkg, msa_shape, msa_front, msa_queue and msa_back.
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//  access  | in        | in_valid / in_stall  | op, write_value, index_0..index_3
//  result  | out       | out_valid / out_stall| read_data, element_offset, status
//
// One access per cycle sustained while in_stall and out_stall stay low, set by the single port of the element memory.
// An access beat passes the front register, the queue and the output register before its result beat.
// After reset and after every write to a defined register the stride sequencer runs
// through its start state and one step per used dimension; in_stall is high meanwhile.
// A stalled result does not block the front: the queue keeps taking beats until full.
module multidim_array_store import msa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     op,
  input  logic signed [DATA_W-1:0] write_value,
  input  logic [IDX_W-1:0]         index_0,
  input  logic [IDX_W-1:0]         index_1,
  input  logic [IDX_W-1:0]         index_2,
  input  logic [IDX_W-1:0]         index_3,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] read_data,
  output logic [OFF_W-1:0]         element_offset,
  output logic [1:0]               status
);

  shape_t                         shape;
  logic [MAX_DIMS-1:0][IDX_W-1:0] index;
  logic                           q_full;
  logic                           q_push;
  acc_t                           q_data;
  logic                           q_valid;
  acc_t                           q_head;
  logic                           q_pop;
  status_t                        out_status;

  assign index[0] = index_0;
  assign index[1] = index_1;
  assign index[2] = index_2;
  assign index[3] = index_3;
  assign status   = out_status;

  msa_shape u_shape (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .shape     (shape)
  );

  msa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .shape       (shape),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op_t'(op)),
    .write_value (write_value),
    .index       (index),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  msa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  msa_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .element_offset (element_offset),
    .status         (out_status)
  );

`ifndef SYNTH
  // strides are being rebuilt right after reset
  a_reset_stalls: assert property (@(posedge clk) rst |=> in_stall)
    else $error("access taken while strides rebuild after reset");

  // a write to a defined register must hold off accesses until the strides are rebuilt
  a_cfg_stalls: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (int'(cfg_index) <= MAX_DIMS)) |=> in_stall)
    else $error("access taken right after a register write");

  // a failed access carries neither data nor offset
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> ((read_data == '0) && (element_offset == '0)))
    else $error("error result carries data or offset");
`endif

endmodule
